[rtl/assert_macros.svh]
// Assertion helpers used by the checker.
// Both expect clk in the scope where they are used; ASSERT_CLK also needs rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/sng_pkg.sv]
`default_nettype none
package sng_pkg;

  // Default geometry
  localparam int SAMPLE_WIDTH_DEF    = 24;
  localparam int COEFF_FRAC_BITS_DEF = 16;

  // Register reset values
  localparam int THRESHOLD_RESET = 83886;
  localparam int ATTACK_RESET    = 297;
  localparam int RELEASE_RESET   = 30;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_GAIN,
    S_LEFT,
    S_RIGHT
  } sng_state_t;

endpackage
`default_nettype wire

[rtl/stereo_noise_gate_top.sv]
// Stereo noise gate: peak envelope follower, hard gate target, smoothed gain.
// Each pair steps through ENV, GAIN, LEFT and RIGHT on the single shared
// multiplier (envelope, gain, left and right products in turn); its result
// is registered once RIGHT finds the output free, and a new pair enters only
// in IDLE or RIGHT. Reset (rst_n low, synchronous): envelope and gain clear
// to zero, the registers take their defaults, the sequencer idles and no result is held.
`default_nettype none
module stereo_noise_gate_top #(
  parameter int SAMPLE_WIDTH    = sng_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEFF_FRAC_BITS = sng_pkg::COEFF_FRAC_BITS_DEF,
  localparam int CfgW = (SAMPLE_WIDTH - 1 > COEFF_FRAC_BITS + 1) ?
                        SAMPLE_WIDTH - 1 : COEFF_FRAC_BITS + 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    in_right_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]    out_right_out,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [sng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CfgW-1:0]                   cfg_wdata
);

  // Widths: magnitudes are SAMPLE_WIDTH-1 bits unsigned, coefficients and
  // gain are Q0.COEFF_FRAC_BITS with one extra bit so unity fits.
  localparam int SW   = SAMPLE_WIDTH;
  localparam int CF   = COEFF_FRAC_BITS;
  localparam int MagW = SW - 1;
  localparam int CoW  = CF + 1;
  localparam int MbW  = CF + 2;                       // signed coeff/gain operand
  localparam int MaW  = (SW > MbW) ? SW : MbW;        // signed data operand
  localparam int PW   = MaW + MbW;                    // product width

  localparam logic [MagW-1:0] SMAX  = {MagW{1'b1}};
  localparam logic [CoW-1:0]  UNITY = {1'b1, {CF{1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers. Coefficients are stored already saturated to
  // unity, which is the only way they are ever used.
  // ---------------------------------------------------------------------
  logic [MagW-1:0] thr_r;
  logic [CoW-1:0]  atk_r, rel_r;
  logic [CoW-1:0]  cfg_coeff;

  always_comb begin
    cfg_coeff = cfg_wdata[CoW-1:0];
    if (cfg_coeff[CF] && (|cfg_coeff[CF-1:0])) begin
      cfg_coeff = UNITY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= MagW'(sng_pkg::THRESHOLD_RESET);
      atk_r <= CoW'(sng_pkg::ATTACK_RESET);
      rel_r <= CoW'(sng_pkg::RELEASE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sng_pkg::REG_THRESHOLD: thr_r <= cfg_wdata[MagW-1:0];
        sng_pkg::REG_ATTACK:    atk_r <= cfg_coeff;
        sng_pkg::REG_RELEASE:   rel_r <= cfg_coeff;
        default: ;  // unmapped index: write is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------
  sng_pkg::sng_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_r || out_ready;
  // A new pair may enter on the last work cycle when the result can leave.
  assign in_ready = (state_r == sng_pkg::S_IDLE) ||
                    ((state_r == sng_pkg::S_RIGHT) && out_free);
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Level detect at the input: larger magnitude of the pair, with the most
  // negative sample saturated to full scale.
  // ---------------------------------------------------------------------
  logic [SW-1:0]   neg_l, neg_r;
  logic [MagW-1:0] mag_l, mag_r, level_in;

  always_comb begin
    neg_l = SW'(0) - in_left_sample;
    neg_r = SW'(0) - in_right_sample;
    mag_l = in_left_sample[SW-1] ? (neg_l[SW-1] ? SMAX : neg_l[MagW-1:0])
                                 : in_left_sample[MagW-1:0];
    mag_r = in_right_sample[SW-1] ? (neg_r[SW-1] ? SMAX : neg_r[MagW-1:0])
                                  : in_right_sample[MagW-1:0];
    level_in = (mag_l > mag_r) ? mag_l : mag_r;
  end

  // Captured transaction
  logic signed [SW-1:0] smp_l_r, smp_r_r;
  logic [MagW-1:0]      level_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      smp_l_r <= in_left_sample;
      smp_r_r <= in_right_sample;
      level_r <= level_in;
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier. Each work state feeds it one operand pair; the
  // product is shifted right arithmetically (floor) by CF.
  //   ENV  : coeff * (level - env)
  //   GAIN : coeff * (target - gain)
  //   LEFT : left  * gain
  //   RIGHT: right * gain
  // ---------------------------------------------------------------------
  logic [MagW-1:0]        env_r, env_nxt;
  logic [CoW-1:0]         gain_r, gain_nxt;
  logic [SW-1:0]          env_diff;
  logic [MbW-1:0]         gain_diff;
  logic [CoW-1:0]         target;
  logic [CoW-1:0]         coef;
  logic signed [MaW-1:0]  mul_a;
  logic signed [MbW-1:0]  mul_b;
  logic signed [PW-1:0]   prod, prod_sh;
  logic signed [PW-1:0]   env_sum, gain_sum;

  always_comb begin
    env_diff  = {1'b0, level_r} - {1'b0, env_r};
    // gate target from the envelope just updated in the ENV step
    target    = (env_r >= thr_r) ? UNITY : '0;
    gain_diff = {1'b0, target} - {1'b0, gain_r};
    coef      = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      sng_pkg::S_ENV: begin
        // equal level takes the release branch
        coef  = (level_r > env_r) ? atk_r : rel_r;
        mul_a = MaW'($signed(env_diff));
        mul_b = $signed({1'b0, coef});
      end
      sng_pkg::S_GAIN: begin
        coef  = (target > gain_r) ? atk_r : rel_r;
        mul_a = MaW'($signed(gain_diff));
        mul_b = $signed({1'b0, coef});
      end
      sng_pkg::S_LEFT: begin
        mul_a = MaW'(smp_l_r);
        mul_b = $signed({1'b0, gain_r});
      end
      sng_pkg::S_RIGHT: begin
        mul_a = MaW'(smp_r_r);
        mul_b = $signed({1'b0, gain_r});
      end
      default: ;
    endcase
    prod     = PW'(mul_a) * PW'(mul_b);
    prod_sh  = prod >>> CF;
    // coefficient <= unity keeps both sums inside their ranges
    env_sum  = PW'($signed({1'b0, env_r}))  + prod_sh;
    gain_sum = PW'($signed({1'b0, gain_r})) + prod_sh;
    env_nxt  = env_sum[MagW-1:0];
    gain_nxt = gain_sum[CoW-1:0];
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sng_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      sng_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = sng_pkg::S_ENV;
        end
      end
      sng_pkg::S_ENV:  state_nxt = sng_pkg::S_GAIN;
      sng_pkg::S_GAIN: state_nxt = sng_pkg::S_LEFT;
      sng_pkg::S_LEFT: state_nxt = sng_pkg::S_RIGHT;
      sng_pkg::S_RIGHT: begin
        // hold the right product until the output register can take it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = accept ? sng_pkg::S_ENV : sng_pkg::S_IDLE;
        end
      end
      default: state_nxt = sng_pkg::S_IDLE;
    endcase
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r  <= '0;
      gain_r <= '0;
    end else begin
      if (state_r == sng_pkg::S_ENV) begin
        env_r <= env_nxt;
      end
      if (state_r == sng_pkg::S_GAIN) begin
        gain_r <= gain_nxt;
      end
    end
  end

  // Result datapath: left is parked until right is done
  logic signed [SW-1:0] left_hold_r;
  logic signed [SW-1:0] out_left_r, out_right_r;

  always_ff @(posedge clk) begin
    if (state_r == sng_pkg::S_LEFT) begin
      left_hold_r <= prod_sh[SW-1:0];
    end
    if ((state_r == sng_pkg::S_RIGHT) && out_free) begin
      out_left_r  <= left_hold_r;
      out_right_r <= prod_sh[SW-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule
`default_nettype wire

[rtl/sng_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module sng_checker #(
  parameter int SAMPLE_WIDTH = sng_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_right_out
);

  // Reset leaves no result pending and the block ready.
  `ASSERT_CLK_ALWAYS(a_reset_state, !rst_n |=> (!out_valid && in_ready), "bad state after reset")

  // A stalled result holds.
  `ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_left_out) && $stable(out_right_out)), "result changed while stalled")

  // The sequencer is busy through ENV, GAIN and LEFT after a transaction.
  `ASSERT_CLK(a_busy, (in_valid && in_ready) |=> (!in_ready ##1 !in_ready ##1 !in_ready), "accepted while busy")

  // A fresh result rises only after an accepted transaction has passed
  // through ENV, GAIN, LEFT and RIGHT.
  `ASSERT_CLK(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 5), "result without matching transaction")

endmodule

bind stereo_noise_gate_top sng_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_sng_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
`default_nettype wire
